// File: rtl/assert_macros.svh
// Assertion macros shared by the filter RTL. The module that uses them
// must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/iirf_pkg.sv
// ----------------------------------------------------------------------------
// IIR filter package
// Opcodes, fixed-point widths, control word types and the microprogram ROM
// shared by the sequencer and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iirf_pkg;

  localparam int COEF_W = 32;
  localparam int PROD_W = 64;
  localparam int Q_FRAC = 24;
  localparam int ACC_W  = 48;
  localparam int UPC_W  = 3;

  typedef enum logic [1:0] {
    OP_FILTER  = 2'd0,
    OP_LOAD_FF = 2'd1,
    OP_LOAD_FB = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MS_NONE,
    MS_FB,
    MS_FF_W,
    MS_FF_D
  } mul_src_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_WAIT_START,
    JC_TAP_LOOP,
    JC_HOME
  } jump_t;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t S_IDLE     = 3'd0;
  localparam upc_t S_FB       = 3'd1;
  localparam upc_t S_DRAIN_FB = 3'd2;
  localparam upc_t S_SAT_W    = 3'd3;
  localparam upc_t S_FF_W     = 3'd4;
  localparam upc_t S_FF_D     = 3'd5;
  localparam upc_t S_DRAIN_FF = 3'd6;
  localparam upc_t S_EMIT     = 3'd7;

  typedef struct packed {
    mul_src_t mul_src;
    jump_t    cond;
    upc_t     target;
    logic     tap_clr;
    logic     tap_inc;
    logic     load_x;
    logic     sat_w;
    logic     emit;
  } cw_t;

  // Control handed from the sequencer to the datapath, already qualified.
  typedef struct packed {
    mul_src_t mul_src;
    logic     load_x;
    logic     sat_w;
    logic     emit;
  } ctrl_t;

  function automatic cw_t micro_rom(input upc_t upc);
    cw_t cw;
    cw = '{mul_src: MS_NONE, cond: JC_NEXT, target: S_IDLE, tap_clr: 1'b0,
           tap_inc: 1'b0, load_x: 1'b0, sat_w: 1'b0, emit: 1'b0};
    case (upc)
      S_IDLE: begin
        cw.cond    = JC_WAIT_START;
        cw.tap_clr = 1'b1;
        cw.load_x  = 1'b1;
      end
      S_FB: begin
        cw.mul_src = MS_FB;
        cw.tap_inc = 1'b1;
        cw.cond    = JC_TAP_LOOP;
        cw.target  = S_FB;
      end
      S_DRAIN_FB: cw.cond = JC_NEXT;
      S_SAT_W:    cw.sat_w = 1'b1;
      S_FF_W:     cw.mul_src = MS_FF_W;
      S_FF_D: begin
        cw.mul_src = MS_FF_D;
        cw.tap_inc = 1'b1;
        cw.cond    = JC_TAP_LOOP;
        cw.target  = S_FF_D;
      end
      S_DRAIN_FF: cw.cond = JC_NEXT;
      S_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = JC_HOME;
        cw.target = S_IDLE;
      end
      default: cw.cond = JC_HOME;
    endcase
    return cw;
  endfunction

endpackage

// File: rtl/iirf_useq.sv
// ----------------------------------------------------------------------------
// IIR filter microsequencer
// Program counter, tap counter and jump logic stepping through the
// microprogram ROM; issues one qualified control word per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iirf_useq #(
  parameter int FILTER_ORDER = 8,
  parameter int TAP_W        = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               out_hold,
  output logic               idle,
  output logic [TAP_W-1:0]   tap,
  output iirf_pkg::ctrl_t    ctrl
);
  import iirf_pkg::*;

  upc_t             upc_r, upc_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;
  cw_t              cw;
  logic             go;
  logic             tap_last;

  assign cw       = micro_rom(upc_r);
  assign tap_last = (tap_r == TAP_W'(FILTER_ORDER - 1));
  // The idle step only advances on a sample, the emit step waits for room.
  assign go = !((cw.cond == JC_WAIT_START) && !start) && !(cw.emit && out_hold);

  always_comb begin
    upc_nxt = upc_r;
    tap_nxt = tap_r;
    if (go) begin
      case (cw.cond)
        JC_NEXT:       upc_nxt = upc_r + upc_t'(1);
        JC_WAIT_START: upc_nxt = upc_r + upc_t'(1);
        JC_TAP_LOOP:   upc_nxt = tap_last ? upc_r + upc_t'(1) : cw.target;
        JC_HOME:       upc_nxt = cw.target;
        default:       upc_nxt = S_IDLE;
      endcase
      if (cw.tap_clr) begin
        tap_nxt = '0;
      end else if (cw.tap_inc) begin
        tap_nxt = tap_last ? '0 : tap_r + TAP_W'(1);
      end
    end
  end

  always_comb begin
    ctrl.mul_src = go ? cw.mul_src : MS_NONE;
    ctrl.load_x  = go && cw.load_x;
    ctrl.sat_w   = go && cw.sat_w;
    ctrl.emit    = go && cw.emit;
  end

  assign idle = (upc_r == S_IDLE);
  assign tap  = tap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
      tap_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      tap_r <= tap_nxt;
    end
  end

  `ASSERT_IMP(a_start_in_idle, start, upc_r == S_IDLE, "sample started outside idle step")
  `ASSERT_NXT(a_emit_returns, ctrl.emit, upc_r == S_IDLE, "emit step did not return home")
  `ASSERT_IMP(a_tap_zero_idle, upc_r == S_IDLE, tap_r == '0, "tap counter not wrapped")

endmodule

// File: rtl/iirf_datapath.sv
// ----------------------------------------------------------------------------
// IIR filter datapath
// Coefficient and delay registers, one shared 32x32 multiplier with a
// registered product, a 48-bit accumulator and the saturation logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iirf_datapath #(
  parameter int FILTER_ORDER = 8,
  parameter int SAMPLE_WIDTH = 16,
  parameter int TAP_W        = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_take,
  input  logic [1:0]                     in_opcode,
  input  logic [3:0]                     in_coeff_index,
  input  logic signed [31:0]             in_coeff_value,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  iirf_pkg::ctrl_t                ctrl,
  input  logic [TAP_W-1:0]               tap,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_out,
  output logic                           out_clipped,
  output logic                           out_hold
);
  import iirf_pkg::*;

  localparam int FF_IW     = $clog2(FILTER_ORDER + 1);
  localparam int FMT_SHIFT = 25 - SAMPLE_WIDTH;

  logic signed [COEF_W-1:0] ff_r [FILTER_ORDER+1];
  logic signed [COEF_W-1:0] fb_r [FILTER_ORDER];
  logic signed [COEF_W-1:0] d_r  [FILTER_ORDER];
  logic signed [COEF_W-1:0] w_r, w_nxt;
  logic                     wclip_r, wclip_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  acc_op_t                  acc_op_r, acc_op_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] y_r, y_nxt;
  logic                     clip_r, clip_nxt;

  logic [FF_IW-1:0]         ff_ridx;
  logic signed [COEF_W-1:0] op_a, op_b;
  logic signed [PROD_W-Q_FRAC-1:0] prod_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  x_ext;
  logic [ACC_W-COEF_W:0]    w_hi;
  logic signed [ACC_W-1:0]  y_sh;
  logic [ACC_W-SAMPLE_WIDTH:0] y_hi;
  logic                     y_sat;
  logic                     load_ff, load_fb;

  assign load_ff = in_take && (in_opcode == OP_LOAD_FF);
  assign load_fb = in_take && (in_opcode == OP_LOAD_FB);

  // Multiplier operands: one coefficient read and one state read per cycle.
  always_comb begin
    ff_ridx = (ctrl.mul_src == MS_FF_W) ? '0 : FF_IW'(tap) + FF_IW'(1);
    case (ctrl.mul_src)
      MS_FB: begin
        op_a = fb_r[tap];
        op_b = d_r[tap];
      end
      MS_FF_W: begin
        op_a = ff_r[ff_ridx];
        op_b = w_r;
      end
      MS_FF_D: begin
        op_a = ff_r[ff_ridx];
        op_b = d_r[tap];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);
    case (ctrl.mul_src)
      MS_FB:          acc_op_nxt = ACC_SUB;
      MS_FF_W,
      MS_FF_D:        acc_op_nxt = ACC_ADD;
      default:        acc_op_nxt = ACC_NONE;
    endcase
  end

  // Product floored to Q.24 and sign-extended into the accumulator.
  assign prod_q   = prod_r[PROD_W-1:Q_FRAC];
  assign prod_ext = {{(ACC_W-PROD_W+Q_FRAC){prod_q[PROD_W-Q_FRAC-1]}}, prod_q};
  assign x_ext    = {{(ACC_W-SAMPLE_WIDTH){in_sample_in[SAMPLE_WIDTH-1]}}, in_sample_in}
                    <<< FMT_SHIFT;

  always_comb begin
    if (ctrl.load_x) begin
      acc_nxt = x_ext;
    end else if (ctrl.sat_w) begin
      acc_nxt = '0;
    end else begin
      case (acc_op_r)
        ACC_ADD: acc_nxt = acc_r + prod_ext;
        ACC_SUB: acc_nxt = acc_r - prod_ext;
        default: acc_nxt = acc_r;
      endcase
    end
  end

  // New state value clamped to the Q8.24 range.
  always_comb begin
    w_hi      = acc_r[ACC_W-1:COEF_W-1];
    w_nxt     = w_r;
    wclip_nxt = wclip_r;
    if (ctrl.sat_w) begin
      wclip_nxt = !((&w_hi) || !(|w_hi));
      if (!wclip_nxt) begin
        w_nxt = acc_r[COEF_W-1:0];
      end else if (acc_r[ACC_W-1]) begin
        w_nxt = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
        w_nxt = {1'b0, {(COEF_W-1){1'b1}}};
      end
    end
  end

  // Output floored back to the sample format and clamped.
  always_comb begin
    y_sh  = acc_r >>> FMT_SHIFT;
    y_hi  = y_sh[ACC_W-1:SAMPLE_WIDTH-1];
    y_sat = !((&y_hi) || !(|y_hi));
    if (!y_sat) begin
      y_nxt = y_sh[SAMPLE_WIDTH-1:0];
    end else if (y_sh[ACC_W-1]) begin
      y_nxt = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y_nxt = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
    clip_nxt = y_sat || wclip_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= FILTER_ORDER; i++) begin
        ff_r[i] <= '0;
      end
      for (int i = 0; i < FILTER_ORDER; i++) begin
        fb_r[i] <= '0;
        d_r[i]  <= '0;
      end
      acc_op_r    <= ACC_NONE;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i <= FILTER_ORDER; i++) begin
        if (load_ff && (int'(in_coeff_index) == i)) begin
          ff_r[i] <= in_coeff_value;
        end
      end
      // Feedback taps are numbered from one.
      for (int i = 0; i < FILTER_ORDER; i++) begin
        if (load_fb && (int'(in_coeff_index) == i + 1)) begin
          fb_r[i] <= in_coeff_value;
        end
      end
      if (ctrl.emit) begin
        d_r[0] <= w_r;
        for (int i = 1; i < FILTER_ORDER; i++) begin
          d_r[i] <= d_r[i-1];
        end
      end
      acc_op_r <= acc_op_nxt;
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    w_r     <= w_nxt;
    wclip_r <= wclip_nxt;
    if (ctrl.emit) begin
      y_r    <= y_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_filtered_out = y_r;
  assign out_clipped      = clip_r;
  assign out_hold         = out_valid_r && !out_ready;

  `ASSERT_NXT(a_emit_valid, ctrl.emit, out_valid, "emitted result not presented")
  `ASSERT_IMP(a_emit_drained, ctrl.emit, acc_op_r == ACC_NONE, "product pending at emit")
  `ASSERT_NXT(a_line_hold, !ctrl.emit, $stable(d_r[0]), "delay line moved without emit")

endmodule

// File: rtl/iir_filter_order8.sv
// Sequence: after a sample is accepted, the shared multiplier takes one tap a cycle, feedback
// then feedforward, with a drain step after each pass and a state saturation step between them.
// Requests, coefficient loads included, are taken only in the idle step, so a new sample waits
// until the last one has been emitted. A waiting result does not stop the next request from being taken.
// Reset: synchronous, active low; coefficients and delay line clear to zero.
// ----------------------------------------------------------------------------
// Eighth-order direct-form-II IIR filter
// Microcoded sequencer driving a single multiply-accumulate datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iir_filter_order8 #(
  parameter int FILTER_ORDER = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic [3:0]                     in_coeff_index,
  input  logic signed [31:0]             in_coeff_value,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_out,
  output logic                           out_clipped
);
  import iirf_pkg::*;

  localparam int TAP_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;

  logic             idle;
  logic             in_take;
  logic             start;
  logic             out_hold;
  logic [TAP_W-1:0] tap;
  ctrl_t            ctrl;

  assign in_ready = idle;
  assign in_take  = in_valid && in_ready;
  assign start    = in_take && (in_opcode == OP_FILTER);

  iirf_useq #(
    .FILTER_ORDER (FILTER_ORDER),
    .TAP_W        (TAP_W)
  ) u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_hold (out_hold),
    .idle     (idle),
    .tap      (tap),
    .ctrl     (ctrl)
  );

  iirf_datapath #(
    .FILTER_ORDER (FILTER_ORDER),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TAP_W        (TAP_W)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_take          (in_take),
    .in_opcode        (in_opcode),
    .in_coeff_index   (in_coeff_index),
    .in_coeff_value   (in_coeff_value),
    .in_sample_in     (in_sample_in),
    .ctrl             (ctrl),
    .tap              (tap),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_filtered_out (out_filtered_out),
    .out_clipped      (out_clipped),
    .out_hold         (out_hold)
  );

endmodule

// File: tb/iir_filter_order8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR filter checker
// Follows every accepted request on the input channel and works out the
// sample that the filter must return. Each result taken from the output
// channel is compared field by field against the oldest outstanding sample.
// ----------------------------------------------------------------------------

module iir_filter_order8_checker #(
  parameter int FILTER_ORDER = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic [3:0]                     in_coeff_index,
  input  logic signed [31:0]             in_coeff_value,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] out_filtered_out,
  input  logic                           out_clipped,
  output int                             fail_count,
  output int                             pending,
  output int                             samples_seen,
  output int                             clips_seen
);

  localparam int     FMT_SHIFT = 25 - SAMPLE_WIDTH;
  localparam longint STATE_MAX = 64'sd2147483647;
  localparam longint STATE_MIN = -STATE_MAX - 1;
  localparam longint OUT_MAX   = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint OUT_MIN   = -OUT_MAX - 1;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           clipped;
  } filter_result_t;

  logic signed [31:0] ff_taps    [0:FILTER_ORDER];
  logic signed [31:0] fb_taps    [1:FILTER_ORDER];
  logic signed [31:0] delay_taps [1:FILTER_ORDER];

  filter_result_t awaited_results [$];

  int errors    = 0;
  int n_samples = 0;
  int n_clips   = 0;

  // Exact Q16.48 product brought back to Q.24, rounding towards minus infinity.
  function automatic longint mul_q24(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
    longint pa;
    longint pb;
    pa = a;
    pb = b;
    return (pa * pb) >>> 24;
  endfunction

  function automatic filter_result_t filter_step(input logic signed [SAMPLE_WIDTH-1:0] smp);
    filter_result_t     r;
    longint             acc_w;
    longint             acc_y;
    logic signed [31:0] w_q24;
    r.clipped = 1'b0;
    acc_w = smp;
    acc_w = acc_w <<< FMT_SHIFT;
    for (int i = 1; i <= FILTER_ORDER; i++) begin
      acc_w -= mul_q24(fb_taps[i], delay_taps[i]);
    end
    if (acc_w > STATE_MAX) begin
      acc_w = STATE_MAX;
      r.clipped = 1'b1;
    end
    if (acc_w < STATE_MIN) begin
      acc_w = STATE_MIN;
      r.clipped = 1'b1;
    end
    w_q24 = acc_w[31:0];

    acc_y = mul_q24(ff_taps[0], w_q24);
    for (int i = 1; i <= FILTER_ORDER; i++) begin
      acc_y += mul_q24(ff_taps[i], delay_taps[i]);
    end

    for (int i = FILTER_ORDER; i > 1; i--) begin
      delay_taps[i] = delay_taps[i-1];
    end
    delay_taps[1] = w_q24;

    acc_y = acc_y >>> FMT_SHIFT;
    if (acc_y > OUT_MAX) begin
      acc_y = OUT_MAX;
      r.clipped = 1'b1;
    end
    if (acc_y < OUT_MIN) begin
      acc_y = OUT_MIN;
      r.clipped = 1'b1;
    end
    r.filtered = acc_y[SAMPLE_WIDTH-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    filter_result_t want;
    if (!rst_n) begin
      for (int i = 0; i <= FILTER_ORDER; i++) ff_taps[i] = '0;
      for (int i = 1; i <= FILTER_ORDER; i++) begin
        fb_taps[i]    = '0;
        delay_taps[i] = '0;
      end
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: filtered_out %0d, clipped %0b",
                 out_filtered_out, out_clipped);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (out_filtered_out !== want.filtered) begin
            $error("filtered_out: expected %0d, actual %0d", want.filtered,
                   out_filtered_out);
            errors++;
          end
          if (out_clipped !== want.clipped) begin
            $error("clipped: expected %0b, actual %0b", want.clipped, out_clipped);
            errors++;
          end
        end
      end

      if (in_valid && in_ready) begin
        case (iirf_pkg::opcode_t'(in_opcode))
          iirf_pkg::OP_FILTER: begin
            want = filter_step(in_sample_in);
            awaited_results.push_back(want);
            n_samples++;
            if (want.clipped) n_clips++;
          end
          iirf_pkg::OP_LOAD_FF: begin
            if (in_coeff_index <= FILTER_ORDER) ff_taps[in_coeff_index] = in_coeff_value;
          end
          iirf_pkg::OP_LOAD_FB: begin
            if (in_coeff_index >= 1 && in_coeff_index <= FILTER_ORDER) begin
              fb_taps[in_coeff_index] = in_coeff_value;
            end
          end
          default: ;
        endcase
      end
    end
    fail_count   <= errors;
    pending      <= awaited_results.size();
    samples_seen <= n_samples;
    clips_seen   <= n_clips;
  end

endmodule

// File: tb/iir_filter_order8_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR filter testbench
// Loads coefficient sets of several kinds into the eighth-order filter and
// streams samples through it, with random idling on both channels; a
// separate checker predicts and compares every filtered sample.
// ----------------------------------------------------------------------------

module iir_filter_order8_test;

  import iirf_pkg::*;

  localparam int SW           = 16;
  localparam int ORDER        = 8;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_ITEMS   = 80;
  localparam int SETTLE       = 30;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {
    SET_GENTLE,
    SET_WIDE,
    SET_FULL,
    SET_FIR
  } coeff_set_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_opcode      = OP_FILTER;
  logic [3:0]            in_coeff_index = '0;
  logic signed [31:0]    in_coeff_value = '0;
  logic signed [SW-1:0]  in_sample_in   = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic signed [SW-1:0]  out_filtered_out;
  logic                  out_clipped;

  int fail_count;
  int pending;
  int samples_seen;
  int clips_seen;

  int cycle_count  = 0;
  int rx_hold      = 0;
  int rx_rate      = 0;
  int rate_timer   = 0;
  int tx_rate      = 0;
  bit calm         = 1'b0;
  int loads_sent   = 0;
  int samples_sent = 0;
  int ignored_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  iir_filter_order8 #(
    .FILTER_ORDER(ORDER),
    .SAMPLE_WIDTH(SW)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_coeff_index  (in_coeff_index),
    .in_coeff_value  (in_coeff_value),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_filtered_out(out_filtered_out),
    .out_clipped     (out_clipped)
  );

  iir_filter_order8_checker #(
    .FILTER_ORDER(ORDER),
    .SAMPLE_WIDTH(SW)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_coeff_index  (in_coeff_index),
    .in_coeff_value  (in_coeff_value),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_filtered_out(out_filtered_out),
    .out_clipped     (out_clipped),
    .fail_count      (fail_count),
    .pending         (pending),
    .samples_seen    (samples_seen),
    .clips_seen      (clips_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: the stall rate is changed each time rate_timer runs out, sometimes to none.
  always @(posedge clk) begin
    if (rate_timer == 0) begin
      rate_timer <= 255;
      case ($urandom_range(0, 2))
        0:       rx_rate <= 0;
        1:       rx_rate <= 4;
        default: rx_rate <= 16;
      endcase
    end else begin
      rate_timer <= rate_timer - 1;
    end
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (!calm && rx_rate != 0 && $urandom_range(1, rx_rate) == 1) begin
      rx_hold   <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Called just after a rising edge; returns just after the edge that accepted
  // the request, or after the idle burst that follows it.
  task automatic send_request(input opcode_t op, input logic [3:0] idx,
                              input logic [31:0] val, input logic [SW-1:0] smp);
    int gap;
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_coeff_index <= idx;
    in_coeff_value <= val;
    in_sample_in   <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_FILTER:  samples_sent++;
      OP_LOAD_FF: if (idx <= ORDER) loads_sent++; else ignored_sent++;
      OP_LOAD_FB: if (idx >= 1 && idx <= ORDER) loads_sent++; else ignored_sent++;
      default:    ignored_sent++;
    endcase
    if (!calm && tx_rate != 0 && $urandom_range(1, tx_rate) == 1) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_sample(input logic [SW-1:0] smp);
    send_request(OP_FILTER, 4'($urandom), $urandom, smp);
  endtask

  task automatic load_ff(input logic [3:0] idx, input logic [31:0] val);
    send_request(OP_LOAD_FF, idx, val, SW'($urandom));
  endtask

  task automatic load_fb(input logic [3:0] idx, input logic [31:0] val);
    send_request(OP_LOAD_FB, idx, val, SW'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] coeff_pick(input coeff_set_t set, input bit feedforward);
    int span;
    case (set)
      SET_GENTLE: span = feedforward ? (1 << 21) : (1 << 20);
      SET_WIDE:   span = feedforward ? (1 << 25) : (1 << 24);
      SET_FIR:    span = feedforward ? (1 << 23) : 0;
      default:    return $urandom;
    endcase
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [SW-1:0] sample_pick();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return SW'($urandom);
    if (roll < 90) return SW'($urandom_range(0, 1024) - 512);
    case ($urandom_range(0, 2))
      0:       return {1'b0, {(SW-1){1'b1}}};
      1:       return {1'b1, {(SW-1){1'b0}}};
      default: return '0;
    endcase
  endfunction

  initial begin
    coeff_set_t set;
    int         nsamp;
    int         roll;
    int         programmes;
    programmes = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: zero taps, unity gain, output and state saturation,
    // out-of-range loads and the unused opcode.
    push_sample(16'sh7FFF);
    load_ff(4'd0, 32'h0100_0000);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    load_ff(4'd0, 32'h7FFF_FFFF);
    push_sample(16'sh7FFF);
    load_ff(4'd9, 32'h1234_5678);
    load_ff(4'd15, 32'hFFFF_FFFF);
    load_fb(4'd0, 32'h7FFF_FFFF);
    load_fb(4'd15, 32'h8000_0000);
    send_request(OP_UNUSED, 4'd15, 32'h7FFF_FFFF, 16'sh7FFF);
    send_request(OP_UNUSED, 4'd0, 32'h8000_0000, 16'sh8000);
    load_ff(4'd0, 32'h0100_0000);
    // A feedback tap of -128 makes the state run away until it saturates.
    load_fb(4'd1, 32'h8000_0000);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    load_fb(4'd8, 32'h7FFF_FFFF);
    load_ff(4'd8, 32'h8000_0000);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    wait_drained();

    while (samples_sent + loads_sent < RANDOM_ITEMS + 20) begin
      set = coeff_set_t'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0:       tx_rate = 0;
        1:       tx_rate = 3;
        default: tx_rate = 10;
      endcase
      for (int i = 0; i <= ORDER; i++) load_ff(4'(i), coeff_pick(set, 1'b1));
      for (int i = 1; i <= ORDER; i++) load_fb(4'(i), coeff_pick(set, 1'b0));
      nsamp = $urandom_range(15, 45);
      repeat (nsamp) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_request(OP_UNUSED, 4'($urandom), $urandom, SW'($urandom));
        end else if (roll < 6) begin
          if ($urandom_range(0, 1) == 1) load_ff(4'($urandom_range(9, 15)), $urandom);
          else load_fb($urandom_range(0, 1) == 1 ? 4'd0 : 4'($urandom_range(9, 15)),
                       $urandom);
        end else if (roll < 10) begin
          // Retune one tap while the delay line holds history.
          if ($urandom_range(0, 1) == 1) load_ff(4'($urandom_range(0, ORDER)),
                                                 coeff_pick(set, 1'b1));
          else load_fb(4'($urandom_range(1, ORDER)), coeff_pick(set, 1'b0));
        end else begin
          push_sample(sample_pick());
        end
      end
      programmes++;
      if (programmes == 3 || $urandom_range(0, 4) == 0) wait_drained();
      if (samples_sent + loads_sent >= RANDOM_ITEMS + 20 - CALM_ITEMS) calm <= 1'b1;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d samples (%0d saturating) and %0d coefficient loads over %0d sets",
             samples_seen, clips_seen, loads_sent, programmes);
    $display("plus %0d ignored requests (unused opcode or tap index out of range)",
             ignored_sent);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/iirf_pkg.sv
rtl/iirf_useq.sv
rtl/iirf_datapath.sv
rtl/iir_filter_order8.sv
tb/iir_filter_order8_checker.sv
tb/iir_filter_order8_test.sv
